### sv/icks_pkg.sv
// Shared types and constants for the streaming Internet checksum block.
// No dependencies; imported by the top level and its port checker.
package icks_pkg;

  localparam int BYTE_W   = 8;
  localparam int SUM_W    = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;

  typedef logic [BYTE_W-1:0]     byte_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Configuration register indexes
  localparam cfg_idx_t CFG_SKIP_ENABLE = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_SKIP_OFFSET = cfg_idx_t'(1);

  localparam sum_t SUM_ALL_ONES = '1;

endpackage

### sv/internet_checksum_stream.sv
// Streaming ones-complement (Internet) checksum over one or two fragments.
// A byte is taken into the input register, then folded into the message state;
// a last byte also loads the result register as it is folded in. Throughput: one
// byte per cycle unless a last byte waits on a full, stalled result register.
// Reset (rst, synchronous): clears the message state, both registers and
// both valid flags. Depends on icks_pkg.
module internet_checksum_stream #(
  parameter int LENGTH_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  icks_pkg::cfg_idx_t cfg_index,
  input  icks_pkg::cfg_data_t cfg_data,
  // byte requests
  input  logic               in_valid,
  output logic               in_stall,
  input  icks_pkg::byte_t    data_byte,
  input  logic               fragment_end,
  input  logic               last,
  // checksum requests
  output logic               out_valid,
  input  logic               out_stall,
  output icks_pkg::sum_t     checksum_value
);
  import icks_pkg::*;

  localparam int CMP_W = (LENGTH_BITS > SUM_W) ? LENGTH_BITS : SUM_W;

  typedef logic [LENGTH_BITS-1:0] pos_t;

  // configuration
  logic      skip_enable;
  logic [SUM_W-1:0] skip_offset;

  // input register
  logic  s1_valid;
  byte_t s1_byte;
  logic  s1_frag_end;
  logic  s1_last;

  // message state
  sum_t  running_sum, running_sum_next;
  byte_t held_high_byte, held_high_byte_next;
  logic  odd_phase, odd_phase_next;
  pos_t  fragment_position, fragment_position_next;
  logic  in_second_fragment, in_second_fragment_next;
  pos_t  fragment_base, fragment_base_next;

  logic  advance;
  logic  in_take;
  logic  end_frag;
  logic  do_add;
  sum_t  word;
  pos_t  start;
  pos_t  where;
  logic  skip_hit;
  logic [SUM_W:0] raw_sum;
  sum_t  folded;
  sum_t  sum_after;
  sum_t  inverted;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_enable <= 1'b0;
      skip_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SKIP_ENABLE: skip_enable <= cfg_data[0];
        CFG_SKIP_OFFSET: skip_offset <= cfg_data[SUM_W-1:0];
        default: ;
      endcase
    end
  end

  // a last byte holds while the result register is full and stalled
  assign advance  = s1_valid && !(s1_last && out_valid && out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte     <= data_byte;
      s1_frag_end <= fragment_end;
      s1_last     <= last;
    end
  end

  // at most one word add per byte: a completed pair, or a padded odd byte at an end
  assign end_frag = s1_last || (s1_frag_end && !in_second_fragment);
  assign do_add   = odd_phase || end_frag;
  assign word     = odd_phase ? {held_high_byte, s1_byte} : {s1_byte, {BYTE_W{1'b0}}};
  assign start    = odd_phase ? (fragment_position - pos_t'(1)) : fragment_position;
  assign where    = fragment_base + start;
  assign skip_hit = skip_enable && (CMP_W'(where) == CMP_W'(skip_offset));
  assign raw_sum  = {1'b0, running_sum} + {1'b0, word};
  assign folded   = raw_sum[SUM_W-1:0] + sum_t'(raw_sum[SUM_W]);
  assign sum_after = (do_add && !skip_hit) ? folded : running_sum;
  assign inverted = ~sum_after;

  always_comb begin
    running_sum_next        = sum_after;
    held_high_byte_next     = held_high_byte;
    odd_phase_next          = 1'b0;
    fragment_position_next  = fragment_position + pos_t'(1);
    in_second_fragment_next = in_second_fragment;
    fragment_base_next      = fragment_base;
    if (!odd_phase) begin
      held_high_byte_next = s1_byte;
      odd_phase_next      = !end_frag;
    end
    priority if (s1_last) begin
      // clear for the next message
      running_sum_next        = '0;
      held_high_byte_next     = '0;
      odd_phase_next          = 1'b0;
      fragment_position_next  = '0;
      in_second_fragment_next = 1'b0;
      fragment_base_next      = '0;
    end else if (s1_frag_end && !in_second_fragment) begin
      fragment_base_next      = fragment_position + pos_t'(1);
      fragment_position_next  = '0;
      in_second_fragment_next = 1'b1;
      held_high_byte_next     = '0;
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum        <= '0;
      held_high_byte     <= '0;
      odd_phase          <= 1'b0;
      fragment_position  <= '0;
      in_second_fragment <= 1'b0;
      fragment_base      <= '0;
    end else if (advance) begin
      running_sum        <= running_sum_next;
      held_high_byte     <= held_high_byte_next;
      odd_phase          <= odd_phase_next;
      fragment_position  <= fragment_position_next;
      in_second_fragment <= in_second_fragment_next;
      fragment_base      <= fragment_base_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last) begin
      checksum_value <= (inverted == '0) ? SUM_ALL_ONES : inverted;
    end
  end

endmodule

### sv/icks_checker.sv
// Port-level checker for internet_checksum_stream, bound to the top level.
// Depends on icks_pkg.
module icks_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input icks_pkg::byte_t     data_byte,
  input logic                fragment_end,
  input logic                last,
  input logic                out_valid,
  input logic                out_stall,
  input icks_pkg::sum_t      checksum_value
);
  import icks_pkg::*;

  // a stalled byte request stays put
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(data_byte) && $stable(fragment_end)
      && $stable(last))
    else $error("byte request dropped or changed under stall");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(checksum_value))
    else $error("result dropped or changed under stall");

  // zero is always sent as all ones
  a_no_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> checksum_value != '0)
    else $error("checksum of zero on the output");

  // input is only held back by a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled without output back-pressure");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind internet_checksum_stream icks_checker u_icks_checker (.*);

### sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for internet_checksum_stream: bytes and register writes in,
// checksums compared against an in-bench ones-complement sum. Depends on icks_pkg.
module tb_top;
  import icks_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic      clk;
  logic      rst = 1'b1;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index = '0;
  cfg_data_t cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  byte_t     data_byte = '0;
  logic      fragment_end = 1'b0;
  logic      last = 1'b0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  sum_t      checksum_value;

  internet_checksum_stream u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
    .fragment_end(fragment_end), .last(last),
    .out_valid(out_valid), .out_stall(out_stall), .checksum_value(checksum_value)
  );

  // bench copy of the registers and message state
  logic        skip_en = 1'b0;
  logic [15:0] skip_off = '0;
  sum_t        ones_sum = '0;
  byte_t       held_hi = '0;
  logic        odd_byte = 1'b0;
  logic [15:0] frag_pos = '0;
  logic [15:0] frag_base = '0;
  logic        second_frag = 1'b0;

  sum_t expected_checksums[$];
  sum_t want;
  int   errors = 0;
  int   cycles = 0;
  int   stall_left = 0;
  logic gaps_on = 1'b1;
  logic stalls_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what, input sum_t got, input sum_t exp_val);
    errors++;
    $display("mismatch at cycle %0d: %s, got %h want %h", cycles, what, got, exp_val);
  endtask

  // add one word unless it starts at the skipped offset; fold the carry back in
  task automatic sum_word(input sum_t word, input logic [15:0] start);
    logic [15:0] where;
    logic [16:0] s;
    where = frag_base + start;
    if (!(skip_en && where == skip_off)) begin
      s = {1'b0, ones_sum} + {1'b0, word};
      ones_sum = s[15:0] + {15'd0, s[16]};
    end
  endtask

  task automatic fold_byte(input byte_t b, input logic fe, input logic lst);
    sum_t c;
    if (!odd_byte) begin
      held_hi = b;
      odd_byte = 1'b1;
    end else begin
      sum_word({held_hi, b}, frag_pos - 16'd1);
      odd_byte = 1'b0;
    end
    frag_pos = frag_pos + 16'd1;
    // pad a lone high byte at the end of a fragment
    if ((lst || (fe && !second_frag)) && odd_byte) begin
      sum_word({held_hi, 8'h00}, frag_pos - 16'd1);
      odd_byte = 1'b0;
    end
    if (lst) begin
      c = ~ones_sum;
      if (c == '0) c = SUM_ALL_ONES;
      expected_checksums.push_back(c);
      ones_sum = '0;
      held_hi = '0;
      frag_pos = '0;
      frag_base = '0;
      second_frag = 1'b0;
    end else if (fe && !second_frag) begin
      frag_base = frag_pos;
      frag_pos = '0;
      second_frag = 1'b1;
      held_hi = '0;
    end
  endtask

  task automatic send_byte(input byte_t b, input logic fe, input logic lst);
    int   gap;
    logic acc;
    gap = gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    fragment_end <= fe;
    last <= lst;
    do begin
      @(negedge clk);
      acc = !in_stall;
      @(posedge clk);
    end while (!acc);
    fold_byte(b, fe, lst);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
    logic acc;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      acc = cfg_ready;
      @(posedge clk);
    end while (!acc);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SKIP_ENABLE: skip_en = val[0];
      CFG_SKIP_OFFSET: skip_off = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // drop valid, drain every outstanding checksum, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_checksums.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_msg(input int len1, input int len2);
    int    total;
    int    kind;
    byte_t b;
    logic  fe;
    total = len1 + len2;
    kind = $urandom_range(0, 5);
    for (int i = 0; i < total; i++) begin
      case (kind)
        0: b = 8'hFF;
        1: b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: b = byte_t'($urandom);
      endcase
      // stray fragment ends in the second fragment are plain data
      if (len2 == 0) fe = (i == total - 1) && ($urandom_range(0, 3) == 0);
      else fe = (i == len1 - 1) || (i >= len1 && $urandom_range(0, 9) == 0);
      send_byte(b, fe, i == total - 1);
    end
  endtask

  task automatic test_directed();
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b1);
    send_byte(8'hAB, 1'b1, 1'b1);
    send_byte(8'h12, 1'b0, 1'b0);
    send_byte(8'h34, 1'b0, 1'b0);
    send_byte(8'h56, 1'b1, 1'b0);
    send_byte(8'h78, 1'b1, 1'b0);
    send_byte(8'h9A, 1'b0, 1'b0);
    send_byte(8'hBC, 1'b0, 1'b1);
    wait_idle();
    // skip the padded odd byte that closes the first fragment
    write_reg(CFG_SKIP_ENABLE, 16'd1);
    write_reg(CFG_SKIP_OFFSET, 16'd2);
    send_byte(8'h12, 1'b0, 1'b0);
    send_byte(8'h34, 1'b0, 1'b0);
    send_byte(8'h56, 1'b1, 1'b0);
    send_byte(8'h78, 1'b0, 1'b0);
    send_byte(8'h9A, 1'b0, 1'b1);
    wait_idle();
    write_reg(CFG_SKIP_OFFSET, 16'd0);
    send_byte(8'hDE, 1'b0, 1'b0);
    send_byte(8'hAD, 1'b0, 1'b0);
    send_byte(8'hBE, 1'b0, 1'b0);
    send_byte(8'hEF, 1'b0, 1'b1);
    wait_idle();
  endtask

  task automatic test_registers();
    write_reg(cfg_idx_t'(8'hFF), 16'hFFFF);
    write_reg(CFG_SKIP_ENABLE, 16'hFFFE);
    write_reg(CFG_SKIP_OFFSET, 16'hFFFF);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h02, 1'b0, 1'b1);
    wait_idle();
    write_reg(CFG_SKIP_ENABLE, 16'h8001);
    write_reg(CFG_SKIP_OFFSET, 16'hFFFE);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b1);
    wait_idle();
  endtask

  task automatic test_random();
    int        items;
    int        msgs;
    int        phase;
    int        len1;
    int        len2;
    cfg_data_t offset;
    items = 0;
    msgs = 0;
    while (items < 500 || msgs < 40) begin
      if (msgs % 8 == 0) begin
        phase = msgs / 8;
        wait_idle();
        gaps_on = (phase != 3);
        stalls_on = (phase != 3);
        if (phase == 2) offset = cfg_data_t'($urandom_range(150, 260));
        else if ($urandom_range(0, 9) == 0) offset = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else offset = cfg_data_t'($urandom_range(0, 24));
        write_reg(CFG_SKIP_ENABLE, phase == 2 ? 16'h0001 : cfg_data_t'($urandom));
        write_reg(CFG_SKIP_OFFSET, offset);
        write_reg(cfg_idx_t'($urandom_range(2, 255)), cfg_data_t'($urandom));
      end
      if (msgs == 20) begin
        len1 = 137;
        len2 = 140;
      end else begin
        len1 = $urandom_range(1, 8);
        len2 = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
      end
      send_msg(len1, len2);
      items += len1 + len2;
      msgs++;
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    wait_idle();
  endtask

  // hold off checksum requests at random
  always @(posedge clk) begin
    if (stall_left == 0 && stalls_on) stall_left = idle_len();
    out_stall <= stalls_on && (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // a request moves at the next rising edge when valid and not stalled here
  always @(negedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_checksums.size() == 0) begin
        report_mismatch("checksum with none expected", checksum_value, '0);
      end else begin
        want = expected_checksums.pop_front();
        if (checksum_value !== want) report_mismatch("checksum_value", checksum_value, want);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_registers();
    test_random();
    wait_idle();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
